@@ hdl/assert_macros.svh @@
// Assertion macros shared by the checker files.
// Depends on nothing; the using scope must provide clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/modexp_pkg.sv @@
// Shared types and default sizes for the modular exponentiation block.
// Used by the controller, the datapath and the top level; depends on nothing.
package modexp_pkg;

    localparam int VALUE_BITS_DEF = 31;
    localparam int EXP_BITS_DEF   = 32;

    // Operation run by the shared serial modular multiplier.
    typedef enum logic [1:0]
    {
        OP_REDUCE = 2'd0,
        OP_MUL    = 2'd1,
        OP_SQR    = 2'd2
    } op_t;

    typedef struct packed
    {
        logic load;
        logic start;
        logic step;
        logic commit;
        logic shift_exp;
        logic out_load;
        op_t  op;
    } cmd_t;

    typedef struct packed
    {
        logic exp_lsb;
        logic mod_small;
    } status_t;

endpackage

@@ hdl/modexp_datapath.sv @@
// Datapath: operand registers and a bit-serial interleaved modular multiplier.
// Depends on modexp_pkg for the command and status structs.
module modexp_datapath #(
    parameter int VALUE_BITS = modexp_pkg::VALUE_BITS_DEF,
    parameter int EXP_BITS   = modexp_pkg::EXP_BITS_DEF
) (
    input  logic                     clk,
    input  modexp_pkg::cmd_t         cmd,
    input  logic [VALUE_BITS-1:0]    base_in,
    input  logic [EXP_BITS-1:0]      exp_in,
    input  logic [VALUE_BITS-1:0]    mod_in,
    output modexp_pkg::status_t      status,
    output logic [VALUE_BITS-1:0]    power
);

    localparam int SUM_W = VALUE_BITS + 2;

    logic [VALUE_BITS-1:0] base_reg;
    logic [EXP_BITS-1:0]   exp_reg;
    logic [VALUE_BITS-1:0] mod_reg;
    logic [SUM_W-1:0]      mod2_reg;
    logic [VALUE_BITS-1:0] acc_reg;
    logic [VALUE_BITS-1:0] sq_reg;
    logic [VALUE_BITS-1:0] x_reg;
    logic [VALUE_BITS-1:0] y_reg;
    logic [VALUE_BITS-1:0] r_reg;
    logic [VALUE_BITS-1:0] power_reg;

    logic [SUM_W-1:0]      sum;
    logic [SUM_W-1:0]      dif1;
    logic [SUM_W-1:0]      dif2;
    logic [VALUE_BITS-1:0] r_next;
    logic                  mod_small;

    // One step: r = 2r + x*ybit, with r, x below m, so the sum stays below 3m.
    assign sum  = {1'b0, r_reg, 1'b0} + (y_reg[VALUE_BITS-1] ? {2'b00, x_reg} : '0);
    assign dif1 = sum - {2'b00, mod_reg};
    assign dif2 = sum - mod2_reg;

    always_comb
    begin
        priority if (sum >= mod2_reg)
            r_next = dif2[VALUE_BITS-1:0];
        else if (sum >= {2'b00, mod_reg})
            r_next = dif1[VALUE_BITS-1:0];
        else
            r_next = sum[VALUE_BITS-1:0];
    end

    assign mod_small = (mod_reg[VALUE_BITS-1:1] == '0);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            base_reg <= base_in;
            exp_reg  <= exp_in;
            mod_reg  <= mod_in;
            mod2_reg <= {1'b0, mod_in, 1'b0};
            acc_reg  <= VALUE_BITS'(1);
        end
        if (cmd.start)
        begin
            r_reg <= '0;
            unique case (cmd.op)
                modexp_pkg::OP_REDUCE:
                begin
                    // Reducing the base is a product with one as multiplicand.
                    x_reg <= VALUE_BITS'(1);
                    y_reg <= base_reg;
                end
                modexp_pkg::OP_MUL:
                begin
                    x_reg <= acc_reg;
                    y_reg <= sq_reg;
                end
                modexp_pkg::OP_SQR:
                begin
                    x_reg <= sq_reg;
                    y_reg <= sq_reg;
                end
                default:
                begin
                    x_reg <= sq_reg;
                    y_reg <= sq_reg;
                end
            endcase
        end
        if (cmd.step)
        begin
            r_reg <= r_next;
            y_reg <= {y_reg[VALUE_BITS-2:0], 1'b0};
        end
        if (cmd.commit)
        begin
            if (cmd.op == modexp_pkg::OP_MUL)
                acc_reg <= r_next;
            else
                sq_reg <= r_next;
        end
        if (cmd.shift_exp)
            exp_reg <= {1'b0, exp_reg[EXP_BITS-1:1]};
        if (cmd.out_load)
            power_reg <= mod_small ? '0 : acc_reg;
    end

    assign status.exp_lsb   = exp_reg[0];
    assign status.mod_small = mod_small;
    assign power            = power_reg;

endmodule

@@ hdl/modexp_ctrl.sv @@
// Controller: sequences base reduction, multiplies and squares per exponent bit.
// Depends on modexp_pkg for the command and status structs.
module modexp_ctrl #(
    parameter int VALUE_BITS = modexp_pkg::VALUE_BITS_DEF,
    parameter int EXP_BITS   = modexp_pkg::EXP_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  modexp_pkg::status_t  status,
    output modexp_pkg::cmd_t     cmd
);

    localparam int STEP_W = $clog2(VALUE_BITS);
    localparam int BIT_W  = $clog2(EXP_BITS);

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_START,
        S_RUN,
        S_BIT,
        S_FINISH
    } state_t;

    state_t            state_reg;
    modexp_pkg::op_t   op_reg;
    logic [STEP_W-1:0] step_cnt_reg;
    logic [BIT_W-1:0]  bit_cnt_reg;
    logic              m_valid_reg;

    logic step_last;
    logic bit_last;
    logic out_free;

    assign step_last = (step_cnt_reg == STEP_W'(VALUE_BITS - 1));
    assign bit_last  = (bit_cnt_reg == BIT_W'(EXP_BITS - 1));
    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_valid_reg;

    always_comb
    begin
        cmd           = '0;
        cmd.op        = op_reg;
        cmd.load      = (state_reg == S_IDLE) && s_tvalid;
        cmd.start     = (state_reg == S_START);
        cmd.step      = (state_reg == S_RUN);
        cmd.commit    = (state_reg == S_RUN) && step_last;
        cmd.shift_exp = (state_reg == S_RUN) && step_last && (op_reg == modexp_pkg::OP_SQR);
        cmd.out_load  = (state_reg == S_FINISH) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            op_reg       <= modexp_pkg::OP_REDUCE;
            step_cnt_reg <= '0;
            bit_cnt_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            // A new result may replace the one taken in the same cycle.
            if (cmd.out_load)
                m_valid_reg <= 1'b1;
            else if (m_valid_reg && m_tready)
                m_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        op_reg      <= modexp_pkg::OP_REDUCE;
                        bit_cnt_reg <= '0;
                        state_reg   <= S_START;
                    end
                end
                S_START:
                begin
                    step_cnt_reg <= '0;
                    // A modulus of zero or one needs no arithmetic at all.
                    if (op_reg == modexp_pkg::OP_REDUCE && status.mod_small)
                        state_reg <= S_FINISH;
                    else
                        state_reg <= S_RUN;
                end
                S_RUN:
                begin
                    step_cnt_reg <= step_cnt_reg + STEP_W'(1);
                    if (step_last)
                    begin
                        unique case (op_reg)
                            modexp_pkg::OP_REDUCE:
                                state_reg <= S_BIT;
                            modexp_pkg::OP_MUL:
                            begin
                                op_reg    <= modexp_pkg::OP_SQR;
                                state_reg <= S_START;
                            end
                            default:
                            begin
                                bit_cnt_reg <= bit_cnt_reg + BIT_W'(1);
                                state_reg   <= bit_last ? S_FINISH : S_BIT;
                            end
                        endcase
                    end
                end
                S_BIT:
                begin
                    op_reg    <= status.exp_lsb ? modexp_pkg::OP_MUL : modexp_pkg::OP_SQR;
                    state_reg <= S_START;
                end
                S_FINISH:
                begin
                    if (out_free)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

@@ hdl/modular_exponentiation_top.sv @@
// Modular exponentiation by right-to-left square-and-multiply.
// Usage:
//   One beat on the s_ side carries base, exponent and modulus; one beat on
//   the m_ side returns base^exponent mod modulus. A modulus of zero or one
//   returns zero, an exponent of zero returns one.
//   Each modular product runs through one bit-serial multiplier, one
//   multiplier bit per cycle. A job runs the base reduction, then per
//   exponent bit a multiply if the bit is set and a square; a modulus
//   below two skips the multiplier. One item is in work at a time.
//   The result sits in an output register: s_tready returns as soon as it
//   is loaded, so the next item runs while the receiver stalls; a finished
//   result waits until that register is free.
//   Reset clears the control state and drops any pending result.
//   Depends on modexp_pkg, modexp_ctrl and modexp_datapath.
module modular_exponentiation_top #(
    parameter int VALUE_BITS = modexp_pkg::VALUE_BITS_DEF,
    parameter int EXP_BITS   = modexp_pkg::EXP_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // Fields from bit 0 up: base, exponent, modulus, zero padding.
    input  logic [((2*VALUE_BITS+EXP_BITS+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // Fields from bit 0 up: power, zero padding.
    output logic [((VALUE_BITS+7)/8)*8-1:0] m_tdata
);

    localparam int OUT_W = ((VALUE_BITS + 7) / 8) * 8;

    modexp_pkg::cmd_t      cmd;
    modexp_pkg::status_t   status;
    logic [VALUE_BITS-1:0] power;

    modexp_ctrl #(
        .VALUE_BITS (VALUE_BITS),
        .EXP_BITS   (EXP_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    modexp_datapath #(
        .VALUE_BITS (VALUE_BITS),
        .EXP_BITS   (EXP_BITS)
    ) u_datapath (
        .clk     (clk),
        .cmd     (cmd),
        .base_in (s_tdata[VALUE_BITS-1:0]),
        .exp_in  (s_tdata[VALUE_BITS+EXP_BITS-1:VALUE_BITS]),
        .mod_in  (s_tdata[2*VALUE_BITS+EXP_BITS-1:VALUE_BITS+EXP_BITS]),
        .status  (status),
        .power   (power)
    );

    assign m_tdata = OUT_W'(power);

endmodule

@@ hdl/modexp_checker.sv @@
// Port-level checker for the modular exponentiation block, bound to the top.
// Depends on assert_macros.svh and on modular_exponentiation_top.
`include "assert_macros.svh"

module modexp_checker #(
    parameter int VALUE_BITS = modexp_pkg::VALUE_BITS_DEF,
    parameter int EXP_BITS   = modexp_pkg::EXP_BITS_DEF
) (
    input logic clk,
    input logic rst_n,
    input logic s_tvalid,
    input logic s_tready,
    input logic [((2*VALUE_BITS+EXP_BITS+7)/8)*8-1:0] s_tdata,
    input logic m_tvalid,
    input logic m_tready,
    input logic [((VALUE_BITS+7)/8)*8-1:0] m_tdata
);

    `ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
    `ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata), "result changed while stalled")
    `ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "accepted a beat while busy")
    `ASSERT_IMPL(a_result_from_work, $rose(m_tvalid), $past(!s_tready), "result without work")

    logic unused_bits;
    assign unused_bits = ^s_tdata;

endmodule

bind modular_exponentiation_top modexp_checker #(
    .VALUE_BITS (VALUE_BITS),
    .EXP_BITS   (EXP_BITS)
) u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// Testbench for modular_exponentiation_top: drives base/exponent/modulus beats and
// checks every returned power against a square-and-multiply predictor kept here.
// Depends on modexp_pkg and the RTL of modular_exponentiation_top.
module testbench;

    localparam int VB    = modexp_pkg::VALUE_BITS_DEF;
    localparam int EB    = modexp_pkg::EXP_BITS_DEF;
    localparam int IN_W  = ((2*VB+EB+7)/8)*8;
    localparam int OUT_W = ((VB+7)/8)*8;
    localparam logic [VB-1:0] VALUE_MAX = {VB{1'b1}};
    localparam logic [EB-1:0] EXP_MAX   = {EB{1'b1}};

    typedef struct
    {
        logic [VB-1:0] base;
        logic [EB-1:0] exponent;
        logic [VB-1:0] modulus;
    } job_t;

    typedef struct
    {
        job_t          job;
        logic [VB-1:0] power;
    } power_due_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    job_t       jobs_to_send[$];
    power_due_t powers_due[$];
    job_t       next_job;
    job_t       seen_job;
    power_due_t oldest;

    logic in_taken = 1'b0;
    logic quiet_tail = 1'b0;
    int   send_gap = 0;
    int   recv_stall = 0;
    int   mismatches = 0;
    int   jobs_accepted = 0;
    int   powers_checked = 0;
    int   trivial_moduli = 0;
    int   zero_exponents = 0;

    modular_exponentiation_top #(
        .VALUE_BITS(VB),
        .EXP_BITS  (EB)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #2 clk = ~clk;

    // Right-to-left square-and-multiply; a modulus below two gives zero.
    function automatic logic [VB-1:0] modular_power(logic [VB-1:0] base,
                                                    logic [EB-1:0] exponent,
                                                    logic [VB-1:0] modulus);
        logic [63:0] acc;
        logic [63:0] sq;
        logic [63:0] m;
        int k;
        if (modulus <= 1)
            return '0;
        m = 64'(modulus);
        acc = 64'd1;
        sq = 64'(base) % m;
        for (k = 0; k < EB; k++)
        begin
            if (exponent[k])
                acc = (acc * sq) % m;
            sq = (sq * sq) % m;
        end
        return acc[VB-1:0];
    endfunction

    task automatic add_job(logic [VB-1:0] base, logic [EB-1:0] exponent,
                           logic [VB-1:0] modulus);
        job_t j;
        j.base = base;
        j.exponent = exponent;
        j.modulus = modulus;
        jobs_to_send.push_back(j);
    endtask

    // Sender: one beat held until accepted, then an optional idle burst that only
    // counts down while the block is ready, so the gap is visible to it.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || in_taken)
        begin
            if (send_gap > 0)
            begin
                s_tvalid <= 1'b0;
                if (s_tready)
                    send_gap <= send_gap - 1;
            end
            else if (jobs_to_send.size() > 0)
            begin
                next_job = jobs_to_send.pop_front();
                s_tdata <= IN_W'({next_job.modulus, next_job.exponent, next_job.base});
                s_tvalid <= 1'b1;
                if (!quiet_tail && $urandom_range(0, 2) == 0)
                    send_gap <= $urandom_range(1, 9);
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
            quiet_tail <= (jobs_to_send.size() <= 40);
        end
    end

    // Receiver: stall bursts are far more likely while a result is offered.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (recv_stall > 0)
        begin
            m_tready <= 1'b0;
            recv_stall <= recv_stall - 1;
        end
        else if (!quiet_tail && $urandom_range(0, m_tvalid ? 3 : 63) == 0)
        begin
            m_tready <= 1'b0;
            recv_stall <= $urandom_range(0, 8);
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // Monitor: predicts on every accepted input beat, checks every output beat.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_taken <= 1'b0;
        end
        else
        begin
            in_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
            begin
                seen_job.base = s_tdata[VB-1:0];
                seen_job.exponent = s_tdata[VB+EB-1:VB];
                seen_job.modulus = s_tdata[2*VB+EB-1:VB+EB];
                powers_due.push_back('{seen_job, modular_power(seen_job.base,
                    seen_job.exponent, seen_job.modulus)});
                jobs_accepted++;
                if (seen_job.modulus <= 1)
                    trivial_moduli++;
                if (seen_job.exponent == 0)
                    zero_exponents++;
            end
            if (m_tvalid && m_tready)
            begin
                if (powers_due.size() == 0)
                begin
                    $display("%0t: unexpected result beat: expected none, got power %0d",
                             $time, m_tdata[VB-1:0]);
                    mismatches++;
                end
                else
                begin
                    oldest = powers_due.pop_front();
                    powers_checked++;
                    if (m_tdata[VB-1:0] !== oldest.power)
                    begin
                        $display({"%0t: power mismatch (base %0d, exponent %0d, ",
                                  "modulus %0d): expected %0d, got %0d"},
                                 $time, oldest.job.base, oldest.job.exponent,
                                 oldest.job.modulus, oldest.power, m_tdata[VB-1:0]);
                        mismatches++;
                    end
                end
            end
        end
    end

    initial
    begin
        int n;
        int pick;
        logic [VB-1:0] m;
        logic [EB-1:0] e;

        // Directed corners: trivial moduli, zero exponent, full-scale operands,
        // a base at or above the modulus, and a few checkable identities.
        add_job('0, '0, 31'd1);
        add_job('0, '0, 31'd0);
        add_job(VALUE_MAX, EXP_MAX, 31'd0);
        add_job(VALUE_MAX, EXP_MAX, 31'd1);
        add_job(31'd5, '0, 31'd7);
        add_job('0, '0, VALUE_MAX);
        add_job('0, 32'd5, 31'd13);
        add_job(VALUE_MAX, EXP_MAX, VALUE_MAX);
        add_job(VALUE_MAX, EXP_MAX, VALUE_MAX - 1);
        add_job(VALUE_MAX - 1, EXP_MAX, VALUE_MAX);
        add_job(31'd2, 32'h8000_0000, VALUE_MAX);
        add_job(31'd3, 32'd1, 31'd2);
        add_job(31'd12345, 32'd1, 31'd1000);
        add_job(31'd999, 32'd3, 31'd999);
        add_job(31'd2, 32'd30, VALUE_MAX);
        add_job(31'h5555_5555, 32'hAAAA_AAAA, 31'h2AAA_AAAB);
        add_job(31'h2AAA_AAAA, 32'h5555_5555, 31'h5555_5555);
        add_job(31'd1, EXP_MAX, 31'd2);
        add_job(31'd46341, 32'd2, VALUE_MAX);
        add_job(31'd2, EXP_MAX, 31'd3);
        // The full-scale modulus is prime, so this one must come back as one.
        add_job(31'd7, 32'(VALUE_MAX - 1), VALUE_MAX);
        add_job(VALUE_MAX - 1, 32'd12345, VALUE_MAX);

        for (n = 0; n < 258; n++)
        begin
            pick = $urandom_range(0, 15);
            m = VB'($urandom);
            e = $urandom;
            if (pick == 0)
                m = VB'($urandom_range(0, 1));
            else if (pick <= 3)
                m = VB'($urandom_range(2, 255));
            else if (pick == 4)
                e = $urandom_range(0, 3);
            add_job(VB'($urandom), e, m);
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (jobs_to_send.size() > 0 || s_tvalid)
            @(posedge clk);
        while (powers_due.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Accepted %0d jobs (%0d with modulus below two, %0d with zero exponent).",
                 jobs_accepted, trivial_moduli, zero_exponents);
        $display("Checked %0d powers, %0d mismatches.", powers_checked, mismatches);
        if (mismatches == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    initial
    begin
        #8_000_000;
        $display("%0t: timeout with %0d results outstanding", $time, powers_due.size());
        $display("testbench: done, errors");
        $finish;
    end

endmodule
